### hw/rtl/weighted_agent_selector_defines.svh
// ---------------------------------------------------------------------------
// Weighted agent selector assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_AGENT_SELECTOR_DEFINES_SVH
`define WEIGHTED_AGENT_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define WAS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define WAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

### hw/rtl/was_pkg.sv
// ---------------------------------------------------------------------------
// was_pkg
// Types and constants shared by the weighted agent selector modules.
// ---------------------------------------------------------------------------
package was_pkg;

	// Commands
	localparam logic [1:0] CMD_UPSERT   = 2'd0;
	localparam logic [1:0] CMD_REMOVE   = 2'd1;
	localparam logic [1:0] CMD_SCHEDULE = 2'd2;
	localparam logic [1:0] CMD_IGNORED  = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_FULL  = 3'd1;
	localparam logic [2:0] ST_NOKEY = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_NONE  = 3'd4;

	// Configuration register indexes
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	localparam logic [4:0]  MAX_RESET  = 5'd16;
	localparam logic [15:0] LOAD_LIMIT = 16'd58982;   // 0.9 in Q0.16
	localparam logic [16:0] T_BIAS     = 17'd1000;
	localparam logic [35:0] MODEL_BIAS = 36'd131072000; // 0.2*1000*65536*10

	// Divide by ten as multiply by ceil(2^23/10), exact for 20-bit operands
	localparam logic [19:0] RECIP_10 = 20'd838861;
	localparam int          RECIP_SH = 23;

	// Score division widths
	localparam int NUM_W = 36;
	localparam int DEN_W = 20;

	localparam int IN_W  = 88;
	localparam int OUT_W = 80;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EVAL,
		S_APPEND,
		S_SH_RD,
		S_SH_WR,
		S_PREP,
		S_MUL,
		S_DIVGO,
		S_DIVWAIT,
		S_PLAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

### hw/rtl/was_ram.sv
// ---------------------------------------------------------------------------
// was_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module was_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/was_div.sv
// ---------------------------------------------------------------------------
// was_div
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per division.
// ---------------------------------------------------------------------------
module was_div
	import was_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// Shift in next numerator bit and trial-subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

### hw/rtl/was_ctrl.sv
// ---------------------------------------------------------------------------
// was_ctrl
// Command sequencer: scans the entry RAM, updates it and scores workers.
// ---------------------------------------------------------------------------
module was_ctrl
	import was_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_BITS    = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic                                         cfg_addr,
	input  logic [4:0]                                   cfg_wdata,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic [IN_W-1:0]                              in_data,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic [OUT_W-1:0]                             out_data,
	output logic                                         ram_we,
	output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
	output logic [KEY_BITS+48:0]                         ram_wdata,
	output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
	input  logic [KEY_BITS+48:0]                         ram_rdata,
	output div_req_t                                     div_req,
	input  div_rsp_t                                     div_rsp
);

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam int KB   = KEY_BITS;
	localparam int EW   = KEY_BITS + 49;

	state_t state_q, state_d;

	logic             mode_q;
	logic [4:0]       max_q;
	logic [1:0]       cmd_q;
	logic [KB-1:0]    key_q;
	logic [15:0]      load_q, succ_q, time_q;
	logic             avl_q;
	logic [CW-1:0]    idx_q, count_q, avail_cnt_q;
	logic [17:0]      best_q;
	logic             win_q;
	logic [KB-1:0]    win_key_q;
	logic [15:0]      win_time_q;
	logic [EW-1:0]    ent_q;
	logic [19:0]      a_q;
	logic [16:0]      t_q;
	logic [NUM_W-1:0] prod_q;
	logic [2:0]       status_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [KB-1:0]    r_key;
	logic [15:0]      r_load;
	logic             r_avl;
	logic             at_end;
	logic             key_hit;
	logic             eligible;
	logic             full;
	logic [CMPW-1:0]  limit;
	logic [CW-1:0]    idx_nx;
	logic             accept;
	logic             emit;
	logic [EW-1:0]    new_entry;
	logic [39:0]      plain_prod;
	logic             score_vld;
	logic [NUM_W-1:0] score;

	// Field views of the entry just read
	always_comb begin
		r_key      = ram_rdata[KB-1:0];
		r_load     = ram_rdata[KB+15:KB];
		r_avl      = ram_rdata[KB+48];
		idx_nx     = idx_q + 1'b1;
		at_end     = idx_q == count_q;
		key_hit    = r_key == key_q;
		eligible   = r_avl && (r_load <= LOAD_LIMIT);
		limit      = (CMPW'(max_q) < CMPW'(TABLE_DEPTH)) ? CMPW'(max_q) : CMPW'(TABLE_DEPTH);
		full       = CMPW'(count_q) >= limit;
		new_entry  = {avl_q, time_q, succ_q, load_q, key_q};
		accept     = in_valid && in_ready;
		emit       = (state_q == S_DONE) && (!out_valid_q || out_ready);
		plain_prod = 40'(a_q) * 40'(RECIP_10);
		score_vld  = (state_q == S_DIVWAIT && div_rsp.done) || (state_q == S_PLAIN);
		score      = (state_q == S_PLAIN) ? prod_q : div_rsp.quot;
	end

	// Next state and memory / divider controls
	always_comb begin
		state_d   = state_q;
		in_ready  = state_q == S_IDLE;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = new_entry;
		ram_raddr = idx_q[IW-1:0];
		div_req.start = 1'b0;
		div_req.num   = NUM_W'(prod_q + MODEL_BIAS + NUM_W'(t_q) * NUM_W'(5));
		div_req.den   = DEN_W'(t_q) * DEN_W'(10);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_data[1:0] == CMD_UPSERT || in_data[1:0] == CMD_REMOVE
						|| in_data[1:0] == CMD_SCHEDULE) ? S_RD : S_DONE;
				end
			end
			S_RD: begin
				if (!at_end) begin
					state_d = S_EVAL;
				end else if (cmd_q == CMD_UPSERT && !full) begin
					state_d = S_APPEND;
				end else begin
					state_d = S_DONE;
				end
			end
			S_EVAL: begin
				priority if (cmd_q == CMD_UPSERT && key_hit) begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end else if (cmd_q == CMD_REMOVE && key_hit) begin
					state_d = S_SH_RD;
				end else if (cmd_q == CMD_SCHEDULE && eligible) begin
					state_d = S_PREP;
				end else begin
					state_d = S_RD;
				end
			end
			S_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[IW-1:0];
				state_d   = S_DONE;
			end
			S_SH_RD: begin
				ram_raddr = idx_nx[IW-1:0];
				state_d   = (idx_nx < count_q) ? S_SH_WR : S_DONE;
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				state_d   = S_SH_RD;
			end
			S_PREP: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = mode_q ? S_DIVGO : S_PLAIN;
			end
			S_DIVGO: begin
				div_req.start = 1'b1;
				state_d       = S_DIVWAIT;
			end
			S_DIVWAIT: begin
				if (div_rsp.done) begin
					state_d = S_RD;
				end
			end
			S_PLAIN: begin
				state_d = S_RD;
			end
			S_DONE: begin
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			max_q  <= MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODE: mode_q <= cfg_wdata[0];
				REG_MAX:  max_q  <= cfg_wdata;
				default:  mode_q <= mode_q;
			endcase
		end
	end

	// Table counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			avail_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EVAL && cmd_q == CMD_UPSERT && key_hit) begin
				avail_cnt_q <= avail_cnt_q - CW'(r_avl) + CW'(avl_q);
			end
			if (state_q == S_EVAL && cmd_q == CMD_REMOVE && key_hit) begin
				avail_cnt_q <= avail_cnt_q - CW'(r_avl);
			end
			if (state_q == S_APPEND) begin
				count_q     <= count_q + 1'b1;
				avail_cnt_q <= avail_cnt_q + CW'(avl_q);
			end
			if (state_q == S_SH_RD && !(idx_nx < count_q)) begin
				count_q <= count_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_data[1:0];
			key_q    <= KB'(in_data[33:2]);
			load_q   <= in_data[49:34];
			succ_q   <= in_data[65:50];
			time_q   <= in_data[81:66];
			avl_q    <= in_data[82];
			idx_q    <= '0;
			best_q   <= '0;
			win_q    <= 1'b0;
			status_q <= ST_OK;
		end
		unique case (state_q)
			S_RD: begin
				if (at_end) begin
					priority if (cmd_q == CMD_UPSERT && full) begin
						status_q <= ST_FULL;
					end else if (cmd_q == CMD_REMOVE) begin
						status_q <= ST_NOKEY;
					end else if (cmd_q == CMD_SCHEDULE && count_q == '0) begin
						status_q <= ST_EMPTY;
					end else if (cmd_q == CMD_SCHEDULE && !win_q) begin
						status_q <= ST_NONE;
					end else begin
						status_q <= status_q;
					end
				end
			end
			S_EVAL: begin
				ent_q <= ram_rdata;
				if (!(cmd_q == CMD_REMOVE && key_hit)) begin
					idx_q <= idx_nx;
				end
			end
			S_SH_WR: begin
				idx_q <= idx_nx;
			end
			S_PREP: begin
				// 0.5/0.7 success plus 0.3 idle share, times ten
				a_q <= mode_q
					? 20'(20'(ent_q[KB+31:KB+16]) * 20'd5 + (20'd65536 - 20'(ent_q[KB+15:KB])) * 20'd3)
					: 20'(20'(ent_q[KB+31:KB+16]) * 20'd7 + (20'd65536 - 20'(ent_q[KB+15:KB])) * 20'd3
						+ 20'd5);
				t_q <= T_BIAS + 17'(ent_q[KB+47:KB+32]);
			end
			S_MUL: begin
				// Model numerator, or the plain score divided by ten
				prod_q <= mode_q ? NUM_W'(a_q) * NUM_W'(t_q)
					: NUM_W'(plain_prod[39:RECIP_SH]);
			end
			S_DIVWAIT, S_PLAIN: begin
				// Keep the first strictly higher score
				if (score_vld && score > NUM_W'(best_q)) begin
					best_q     <= 18'(score);
					win_q      <= 1'b1;
					win_key_q  <= ent_q[KB-1:0];
					win_time_q <= ent_q[KB+47:KB+32];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {2'b00,
				5'(count_q),
				5'(avail_cnt_q),
				win_q ? win_time_q : 16'd0,
				win_q ? best_q[16:0] : 17'd0,
				win_q ? 32'(win_key_q) : 32'd0,
				status_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hw/rtl/weighted_agent_selector.sv
// ---------------------------------------------------------------------------
// weighted_agent_selector
// Ordered worker table with upsert, remove and score-based scheduling.
// ---------------------------------------------------------------------------
// Usage: items enter on the s_axis channel, one command each; every item
// yields exactly one result beat on m_axis. cfg_we/cfg_addr/cfg_wdata set
// model_mode (index 0) and max_entries (index 1) while the block is idle.
// Sequencing: while it searches, the sequencer reads each RAM entry in
// S_RD and evaluates it in S_EVAL. A remove moves each later entry down
// with a read and a write state. Schedule scores each eligible worker
// through S_PREP and S_MUL, then S_PLAIN (plain) or the score divider
// (model). A command other than the three goes straight to its result.
// One item is in work at a time.
// Reset clears the entry count, the available count, the state, the output
// valid and the configuration registers; entry contents are not cleared and
// need no clearing pass. A stalled receiver holds the result in the output
// register; the next item is still taken and runs until its own result is ready.
// ---------------------------------------------------------------------------
module weighted_agent_selector
	import was_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_BITS    = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [4:0]       cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// command, agent_key, load_fraction, success_fraction, response_time_ms,
	// available, zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status, selected_key, confidence, worker_time_ms, available_count,
	// total_count, zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EW = KEY_BITS + 49;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	div_req_t      div_req;
	div_rsp_t      div_rsp;

	// Entry table
	was_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Score divider
	was_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer
	was_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS   (KEY_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

endmodule

### hw/rtl/was_checker.sv
// ---------------------------------------------------------------------------
// was_checker
// Port-level checks for the weighted agent selector, bound to the top level.
// ---------------------------------------------------------------------------
`include "weighted_agent_selector_defines.svh"

module was_checker
	import was_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	logic in_beat;
	logic fail_beat;

	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign fail_beat = m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK);

	// Stalled result beat holds
	`WAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// One item in work at a time
	`WAS_ASSERT_NEXT(a_one_item, in_beat, !s_axis_tready)

	// Failed commands report no worker
	`WAS_ASSERT_NOW(a_fail_zero, fail_beat,
		m_axis_tdata[67:3] == 65'd0)

	// Available workers never outnumber the table
	`WAS_ASSERT_NOW(a_counts, m_axis_tvalid,
		m_axis_tdata[72:68] <= m_axis_tdata[77:73])

	// Status is one of the defined codes
	`WAS_ASSERT_NOW(a_status_range, m_axis_tvalid,
		m_axis_tdata[2:0] <= ST_NONE)

endmodule

bind weighted_agent_selector was_checker u_was_checker (.*);

### tb/weighted_agent_selector_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted agent selector checker
// Watches the register port and both streams, keeps its own copy of the
// worker table, predicts one result beat per command and compares it.
// ---------------------------------------------------------------------------
module weighted_agent_selector_checker
	import was_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [4:0]       cfg_wdata,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int               pending,
	output int               errors
);

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] sel_key;
		logic [16:0] conf;
		logic [15:0] est_ms;
		logic [4:0]  avail_cnt;
		logic [4:0]  total_cnt;
	} sel_result_t;

	logic [31:0] tbl_key[DEPTH];
	logic [15:0] tbl_load[DEPTH];
	logic [15:0] tbl_succ[DEPTH];
	logic [15:0] tbl_time[DEPTH];
	logic        tbl_avail[DEPTH];
	int          tbl_count;
	logic        mode;
	logic [4:0]  max_ent;
	sel_result_t expected_results[$];

	// Score of one table entry, Q1.16, rounded half up
	function automatic longint unsigned worker_score(int i);
		longint unsigned s, l, t, num, den;
		s = tbl_succ[i];
		l = 65536 - longint'(tbl_load[i]);
		if (!mode)
			return (7 * s + 3 * l + 5) / 10;
		t = 1000 + longint'(tbl_time[i]);
		num = (5 * s + 3 * l) * t + 131072000;
		den = 10 * t;
		return (num + den / 2) / den;
	endfunction

	function automatic int find_worker(logic [31:0] key);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	// Apply one command to the table and queue the result it should give
	task automatic run_command(logic [IN_W-1:0] d);
		logic [1:0]      cmd;
		logic [31:0]     key;
		sel_result_t     r;
		int              pos, limit, win, avail;
		longint unsigned best, sc;
		cmd = d[1:0];
		key = d[33:2];
		r = '0;
		r.status = ST_OK;
		limit = (max_ent < DEPTH) ? max_ent : DEPTH;
		pos = find_worker(key);
		if (cmd == CMD_UPSERT) begin
			if (pos < 0 && tbl_count >= limit) begin
				r.status = ST_FULL;
			end else begin
				if (pos < 0) begin
					pos = tbl_count;
					tbl_count++;
				end
				tbl_key[pos] = key;
				tbl_load[pos] = d[49:34];
				tbl_succ[pos] = d[65:50];
				tbl_time[pos] = d[81:66];
				tbl_avail[pos] = d[82];
			end
		end else if (cmd == CMD_REMOVE) begin
			if (pos < 0) begin
				r.status = ST_NOKEY;
			end else begin
				for (int i = pos; i + 1 < tbl_count; i++) begin
					tbl_key[i] = tbl_key[i + 1];
					tbl_load[i] = tbl_load[i + 1];
					tbl_succ[i] = tbl_succ[i + 1];
					tbl_time[i] = tbl_time[i + 1];
					tbl_avail[i] = tbl_avail[i + 1];
				end
				tbl_count--;
			end
		end else if (cmd == CMD_SCHEDULE) begin
			if (tbl_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				best = 0;
				win = -1;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_avail[i] && tbl_load[i] <= LOAD_LIMIT) begin
						sc = worker_score(i);
						if (sc > best) begin
							best = sc;
							win = i;
						end
					end
				end
				if (win < 0) begin
					r.status = ST_NONE;
				end else begin
					r.sel_key = tbl_key[win];
					r.conf = best[16:0];
					r.est_ms = tbl_time[win];
				end
			end
		end
		avail = 0;
		for (int i = 0; i < tbl_count; i++)
			if (tbl_avail[i])
				avail++;
		r.avail_cnt = avail[4:0];
		r.total_cnt = tbl_count[4:0];
		expected_results.push_back(r);
	endtask

	task automatic check_beat(logic [OUT_W-1:0] d);
		sel_result_t e, a;
		a.status = d[2:0];
		a.sel_key = d[34:3];
		a.conf = d[51:35];
		a.est_ms = d[67:52];
		a.avail_cnt = d[72:68];
		a.total_cnt = d[77:73];
		if (expected_results.size() == 0) begin
			$error("result beat with nothing expected: %h", d);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		if (a.status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, a.status);
			errors++;
		end
		if (a.sel_key !== e.sel_key) begin
			$error("selected_key: expected %h, got %h", e.sel_key, a.sel_key);
			errors++;
		end
		if (a.conf !== e.conf) begin
			$error("confidence: expected %0d, got %0d", e.conf, a.conf);
			errors++;
		end
		if (a.est_ms !== e.est_ms) begin
			$error("worker_time_ms: expected %0d, got %0d", e.est_ms, a.est_ms);
			errors++;
		end
		if (a.avail_cnt !== e.avail_cnt) begin
			$error("available_count: expected %0d, got %0d", e.avail_cnt, a.avail_cnt);
			errors++;
		end
		if (a.total_cnt !== e.total_cnt) begin
			$error("total_count: expected %0d, got %0d", e.total_cnt, a.total_cnt);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	// Track registers, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_count = 0;
			mode = 1'b0;
			max_ent = MAX_RESET;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_MODE)
					mode = cfg_wdata[0];
				else
					max_ent = cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready)
				check_beat(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				run_command(s_axis_tdata);
		end
		pending = expected_results.size();
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted agent selector testbench
// Drives directed and random worker commands under several register
// settings with random idling on both streams; the checker scores results.
// ---------------------------------------------------------------------------
module tb_top;
	import was_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1080;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_addr;
	logic [4:0]       cfg_wdata;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	int               pending;
	int               errors;
	int               cycles;
	logic             steady;
	logic [31:0]      key_pool[24];

	weighted_agent_selector uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	weighted_agent_selector_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.pending(pending), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Stall the result stream at random unless in a steady stretch
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 19);

	// Send one command beat, with random idle cycles ahead of it
	task automatic send_cmd(logic [1:0] cmd, logic [31:0] key, logic [15:0] load,
			logic [15:0] succ, logic [15:0] rtime, logic avail);
		while (!steady && $urandom_range(99) < 19) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, avail, rtime, succ, load, key, cmd};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drain all results, then write both registers
	task automatic set_regs(logic mode, logic [4:0] max_ent);
		s_axis_tvalid <= 1'b0;
		// Let the checker see the last accepted beat first
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_MODE;
		cfg_wdata <= {4'd0, mode};
		@(posedge clk);
		cfg_addr <= REG_MAX;
		cfg_wdata <= max_ent;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_cmd();
		int          pick;
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [15:0] load;
		pick = $urandom_range(99);
		cmd = (pick < 45) ? CMD_UPSERT : (pick < 65) ? CMD_REMOVE :
			(pick < 95) ? CMD_SCHEDULE : CMD_IGNORED;
		key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(23)];
		load = $urandom_range(1) ? 16'($urandom_range(58982)) : 16'($urandom());
		send_cmd(cmd, key, load, 16'($urandom()), 16'($urandom()),
			$urandom_range(99) < 80);
	endtask

	initial begin
		logic       modes[6];
		logic [4:0] limits[6];
		modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		limits = '{5'd16, 5'd16, 5'd1, 5'd3, 5'd8, 5'd16};
		for (int i = 0; i < 24; i++)
			key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_MODE;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unknown command, field extremes, load edge
		send_cmd(CMD_SCHEDULE, '0, '0, '0, '0, 1'b0);
		send_cmd(CMD_REMOVE, 32'h1234, '0, '0, '0, 1'b0);
		send_cmd(CMD_IGNORED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_cmd(CMD_UPSERT, 32'h0, 16'd0, 16'hFFFF, 16'd0, 1'b1);
		send_cmd(CMD_UPSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_cmd(CMD_UPSERT, 32'h5, 16'd58982, 16'd100, 16'hFFFF, 1'b1);
		send_cmd(CMD_UPSERT, 32'h6, 16'd58983, 16'hFFFF, 16'd5, 1'b1);
		send_cmd(CMD_UPSERT, 32'h7, 16'd0, 16'hFFFF, 16'd0, 1'b0);
		send_cmd(CMD_SCHEDULE, '0, '0, '0, '0, 1'b0);
		send_cmd(CMD_UPSERT, 32'h0, 16'd0, 16'd0, 16'd0, 1'b0);
		send_cmd(CMD_SCHEDULE, '0, '0, '0, '0, 1'b0);
		send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
		send_cmd(CMD_REMOVE, 32'hABCD, '0, '0, '0, 1'b0);
		send_cmd(CMD_UPSERT, 32'h6, 16'hFFFF, 16'd0, 16'd0, 1'b1);
		send_cmd(CMD_SCHEDULE, '0, '0, '0, '0, 1'b0);
		// Fill the table, append past full, then update while full
		for (int i = 0; i < 13; i++)
			send_cmd(CMD_UPSERT, 32'h100 + 32'(i), 16'($urandom()), 16'($urandom()),
				16'($urandom()), 1'b1);
		send_cmd(CMD_UPSERT, 32'h200, '0, '0, '0, 1'b1);
		send_cmd(CMD_UPSERT, 32'h5, 16'd10, 16'd60000, 16'd1, 1'b1);
		send_cmd(CMD_SCHEDULE, '0, '0, '0, '0, 1'b0);
		set_regs(1'b1, 5'd16);
		send_cmd(CMD_SCHEDULE, '0, '0, '0, '0, 1'b0);

		// Random phases under several register settings
		for (int p = 0; p < 6; p++) begin
			set_regs(modes[p], limits[p]);
			for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
				steady <= (n >= 60 && n < 100);
				random_cmd();
			end
		end
		s_axis_tvalid <= 1'b0;
		steady <= 1'b0;

		// Let the checker see the last accepted beat, then drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/was_pkg.sv
hw/rtl/was_ram.sv
hw/rtl/was_div.sv
hw/rtl/was_ctrl.sv
hw/rtl/weighted_agent_selector.sv
hw/rtl/was_checker.sv
tb/weighted_agent_selector_checker.sv
tb/tb_top.sv
